>>> hw/rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants for the nearest palette colour search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

  // Palette size and derived address width
  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

  // Fixed field widths
  localparam int IDX_W   = 12;
  localparam int CHAN_W  = 8;
  localparam int SQ_W    = 2 * CHAN_W;
  localparam int WGT_W   = 10;
  localparam int DIST_W  = 26;

  // Perceptual weights scaled by 1000
  localparam logic [WGT_W-1:0] W_RED   = WGT_W'(299);
  localparam logic [WGT_W-1:0] W_GREEN = WGT_W'(587);
  localparam logic [WGT_W-1:0] W_BLUE  = WGT_W'(114);

  // Largest distance the weights can produce
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(65025000);

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_MATCH = 1'b1;

  // One palette entry
  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  // Tag carried alongside each entry through the distance pipeline
  typedef struct packed {
    logic              vld;
    logic              fin;
    logic [ADDR_W-1:0] addr;
  } tag_t;

endpackage

>>> hw/rtl/nearest_palette_color_search_top.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// A load word (cmd 0) writes one palette entry; indices at or beyond
// TABLE_ENTRIES are dropped. A match word (cmd 1) scans the whole palette,
// one entry read from the palette memory per cycle, and returns the closest
// entry under 299*dr^2 + 587*dg^2 + 114*db^2, lowest index on ties.
// A match reads every entry through the single read port of the palette
// memory and then the distance pipeline. The result sits in an output
// register, so a new word is taken while the previous result waits; a
// finished scan waits only if that register is still full. Entries must be
// loaded before a match reads them.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top
  import npcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [CHAN_W-1:0] in_red,
  input  logic [CHAN_W-1:0] in_green,
  input  logic [CHAN_W-1:0] in_blue,
  input  logic              in_is_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_best_index,
  output logic [CHAN_W-1:0] out_match_red,
  output logic [CHAN_W-1:0] out_match_green,
  output logic [CHAN_W-1:0] out_match_blue,
  output logic [DIST_W-1:0] out_best_distance,
  output logic              out_last_out
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t            state_r, state_nxt;
  logic              in_acc, wr_in_range, ram_we, ram_re;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              issued_r, issued_nxt;
  logic              first_r, first_nxt;
  rgb_t              query_r, wdata, rdata, d_entry;
  logic              last_r;
  tag_t              tag0_r, tag0_nxt, d_tag;
  logic [DIST_W-1:0] d_dist;
  logic              take_best, out_free;
  logic [DIST_W-1:0] best_dist_r;
  logic [ADDR_W-1:0] best_addr_r;
  rgb_t              best_entry_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_idx_r;
  rgb_t              out_rgb_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_last_r;

  // Input handshake and palette write
  assign in_stall    = (state_r != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign wr_in_range = (32'(in_entry_index) < TABLE_ENTRIES);
  assign ram_we      = in_acc && (in_cmd == CMD_LOAD) && wr_in_range;
  assign wdata       = '{r: in_red, g: in_green, b: in_blue};
  assign out_free    = !out_valid_r || !out_stall;

  // Read issue: one address a cycle until the last entry
  always_comb begin
    ram_re       = (state_r == S_SCAN) && !issued_r;
    cnt_nxt      = cnt_r;
    issued_nxt   = issued_r;
    tag0_nxt.vld = ram_re;
    tag0_nxt.fin = (cnt_r == ADDR_W'(TABLE_ENTRIES - 1));
    tag0_nxt.addr = cnt_r;
    if (in_acc && (in_cmd == CMD_MATCH)) begin
      cnt_nxt    = '0;
      issued_nxt = 1'b0;
    end else if (ram_re) begin
      cnt_nxt = cnt_r + 1'b1;
      if (tag0_nxt.fin) begin
        issued_nxt = 1'b1;
      end
    end
  end

  npcs_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_entry_index)),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (cnt_r),
    .rdata (rdata)
  );

  npcs_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .query     (query_r),
    .entry     (rdata),
    .tag_in    (tag0_r),
    .entry_out (d_entry),
    .tag_out   (d_tag),
    .distance  (d_dist)
  );

  // Running best; strict compare keeps the lowest index on ties
  assign take_best = d_tag.vld && (first_r || (d_dist < best_dist_r));

  always_comb begin
    first_nxt = first_r;
    if (in_acc && (in_cmd == CMD_MATCH)) begin
      first_nxt = 1'b1;
    end else if (d_tag.vld) begin
      first_nxt = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == CMD_MATCH)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (d_tag.vld && d_tag.fin) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, control and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      issued_r    <= 1'b1;
      first_r     <= 1'b1;
      tag0_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      issued_r <= issued_nxt;
      first_r  <= first_nxt;
      tag0_r   <= tag0_nxt;
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc && (in_cmd == CMD_MATCH)) begin
      query_r <= wdata;
      last_r  <= in_is_last;
    end
    if (take_best) begin
      best_dist_r  <= d_dist;
      best_addr_r  <= d_tag.addr;
      best_entry_r <= d_entry;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_idx_r  <= IDX_W'(best_addr_r);
      out_rgb_r  <= best_entry_r;
      out_dist_r <= best_dist_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_best_index    = out_idx_r;
  assign out_match_red     = out_rgb_r.r;
  assign out_match_green   = out_rgb_r.g;
  assign out_match_blue    = out_rgb_r.b;
  assign out_best_distance = out_dist_r;
  assign out_last_out      = out_last_r;

`ifndef ASSERT_OFF
  // No palette write may land while a scan is reading
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("palette written during scan");

  // Distance pipeline only carries entries during a scan
  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    d_tag.vld |-> (state_r == S_SCAN))
    else $error("distance word outside scan");

  // The final entry closes the scan
  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    (d_tag.vld && d_tag.fin) |=> (state_r == S_DONE))
    else $error("scan did not finish after last entry");

  // Best distance never exceeds the weighted maximum
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (best_dist_r <= DIST_MAX))
    else $error("best distance out of range");
`endif

endmodule

>>> hw/rtl/npcs_ram.sv
// ----------------------------------------------------------------------------
// npcs_ram
// Palette store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module npcs_ram
  import npcs_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  rgb_t              wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output rgb_t              rdata
);

  rgb_t mem [TABLE_ENTRIES];
  rgb_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/npcs_dist.sv
// ----------------------------------------------------------------------------
// npcs_dist
// Weighted squared distance pipeline: squares, then weighting, then sum.
// ----------------------------------------------------------------------------
module npcs_dist
  import npcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  rgb_t              query,
  input  rgb_t              entry,
  input  tag_t              tag_in,
  output rgb_t              entry_out,
  output tag_t              tag_out,
  output logic [DIST_W-1:0] distance
);

  logic [CHAN_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]   sq_r_nxt, sq_g_nxt, sq_b_nxt;
  logic [SQ_W-1:0]   sq_r_r, sq_g_r, sq_b_r;
  rgb_t              ent1_r, ent2_r;
  tag_t              tag1_r, tag2_r;
  logic [DIST_W-1:0] pr_r, pg_r, pb_r;
  logic [DIST_W-1:0] pr_nxt, pg_nxt, pb_nxt;

  // Absolute differences and squares
  always_comb begin
    dr       = (query.r > entry.r) ? (query.r - entry.r) : (entry.r - query.r);
    dg       = (query.g > entry.g) ? (query.g - entry.g) : (entry.g - query.g);
    db       = (query.b > entry.b) ? (query.b - entry.b) : (entry.b - query.b);
    sq_r_nxt = SQ_W'(dr) * SQ_W'(dr);
    sq_g_nxt = SQ_W'(dg) * SQ_W'(dg);
    sq_b_nxt = SQ_W'(db) * SQ_W'(db);
  end

  // Weighting by constant
  always_comb begin
    pr_nxt = DIST_W'(sq_r_r) * DIST_W'(W_RED);
    pg_nxt = DIST_W'(sq_g_r) * DIST_W'(W_GREEN);
    pb_nxt = DIST_W'(sq_b_r) * DIST_W'(W_BLUE);
  end

  // Tag stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    sq_r_r <= sq_r_nxt;
    sq_g_r <= sq_g_nxt;
    sq_b_r <= sq_b_nxt;
    ent1_r <= entry;
    pr_r   <= pr_nxt;
    pg_r   <= pg_nxt;
    pb_r   <= pb_nxt;
    ent2_r <= ent1_r;
  end

  // Sum fits in DIST_W by construction
  assign distance  = pr_r + pg_r + pb_r;
  assign entry_out = ent2_r;
  assign tag_out   = tag2_r;

endmodule

>>> bench/tb_nearest_palette_color_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_search_top
// Fills the palette, runs directed and random load/match words through the
// block with random idling on both sides and one long output hold-off, and
// checks every result against a behavioural nearest-colour search.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_search_top;
  import npcs_pkg::*;

  // Perceptual weights, scaled by 1000
  localparam int unsigned WEIGHT_R = 299;
  localparam int unsigned WEIGHT_G = 587;
  localparam int unsigned WEIGHT_B = 114;

  localparam int POOL_SIZE   = 24;
  localparam int TAIL_WORDS  = 30;       // no idling once this few words remain
  localparam int HOLD_CYCLES = 15000;    // long output hold-off, several scans
  localparam int LIMIT       = 3000000;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] entry_index;
    rgb_t             colour;
    logic             is_last;
  } word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    rgb_t              colour;
    logic [DIST_W-1:0] distance;
    logic              last;
  } match_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_cmd = CMD_LOAD;
  logic [IDX_W-1:0]  in_entry_index = '0;
  logic [CHAN_W-1:0] in_red = '0;
  logic [CHAN_W-1:0] in_green = '0;
  logic [CHAN_W-1:0] in_blue = '0;
  logic              in_is_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IDX_W-1:0]  out_best_index;
  logic [CHAN_W-1:0] out_match_red;
  logic [CHAN_W-1:0] out_match_green;
  logic [CHAN_W-1:0] out_match_blue;
  logic [DIST_W-1:0] out_best_distance;
  logic              out_last_out;

  word_t  pending_words[$];
  match_t expected_matches[$];
  rgb_t   palette_copy[TABLE_ENTRIES];
  rgb_t   colour_pool[POOL_SIZE];

  int errors = 0;
  int results_seen = 0;
  int hold_at = 1 << 30;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int cycle_count = 0;

  nearest_palette_color_search_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_entry_index   (in_entry_index),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_best_index   (out_best_index),
    .out_match_red    (out_match_red),
    .out_match_green  (out_match_green),
    .out_match_blue   (out_match_blue),
    .out_best_distance(out_best_distance),
    .out_last_out     (out_last_out)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned sq_diff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    int unsigned d;
    d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return d * d;
  endfunction

  function automatic int unsigned colour_distance(rgb_t q, rgb_t e);
    return WEIGHT_R * sq_diff(q.r, e.r) + WEIGHT_G * sq_diff(q.g, e.g)
         + WEIGHT_B * sq_diff(q.b, e.b);
  endfunction

  // Full palette walk; an entry wins only when strictly closer
  function automatic match_t nearest_entry(rgb_t q, logic last);
    match_t      m;
    int unsigned best;
    int unsigned d;
    int          j;
    best     = colour_distance(q, palette_copy[0]);
    m.idx    = '0;
    m.colour = palette_copy[0];
    for (j = 1; j < TABLE_ENTRIES; j++) begin
      d = colour_distance(q, palette_copy[j]);
      if (d < best) begin
        best     = d;
        m.idx    = j[IDX_W-1:0];
        m.colour = palette_copy[j];
      end
    end
    m.distance = best[DIST_W-1:0];
    m.last     = last;
    return m;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  task automatic push_load(int idx, rgb_t c);
    word_t w;
    w.cmd         = CMD_LOAD;
    w.entry_index = idx[IDX_W-1:0];
    w.colour      = c;
    w.is_last     = 1'($urandom_range(0, 1));   // ignored by loads
    pending_words.push_back(w);
  endtask

  task automatic push_match(rgb_t c, logic last);
    word_t w;
    w.cmd         = CMD_MATCH;
    w.entry_index = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    w.colour      = c;
    w.is_last     = last;
    pending_words.push_back(w);
  endtask

  function automatic rgb_t mk_rgb(int r, int g, int b);
    rgb_t c;
    c.r = r[CHAN_W-1:0];
    c.g = g[CHAN_W-1:0];
    c.b = b[CHAN_W-1:0];
    return c;
  endfunction

  function automatic rgb_t random_rgb();
    return mk_rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // Half of the entries come from a small pool, so duplicates and ties are common
  function automatic rgb_t pick_colour();
    if ($urandom_range(0, 1) == 0)
      return colour_pool[$urandom_range(0, POOL_SIZE - 1)];
    return random_rgb();
  endfunction

  function automatic int nudge(int v);
    int n;
    n = v + int'($urandom_range(0, 16)) - 8;
    return (n < 0) ? 0 : (n > 255) ? 255 : n;
  endfunction

  // ---------------------------------------------------------------- sequence and end of run
  initial begin
    int   k;
    int   n_matches;
    rgb_t c;
    n_matches = 0;
    for (k = 0; k < POOL_SIZE; k++) colour_pool[k] = random_rgb();

    // All-black palette, then directed cases
    for (k = 0; k < TABLE_ENTRIES; k++) push_load(k, mk_rgb(0, 0, 0));
    push_match(mk_rgb(255, 255, 255), 1'b1);   // largest distance, tie on every entry
    push_match(mk_rgb(0, 0, 0), 1'b0);
    push_load(TABLE_ENTRIES - 1, mk_rgb(255, 255, 255));
    push_match(mk_rgb(255, 255, 255), 1'b1);   // top entry wins
    push_match(mk_rgb(128, 128, 128), 1'b0);
    push_load(TABLE_ENTRIES / 2, mk_rgb(255, 255, 255));
    push_match(mk_rgb(255, 255, 255), 1'b1);   // duplicate colour, lower index kept
    push_load(100, mk_rgb(10, 0, 0));
    push_load(200, mk_rgb(30, 0, 0));
    push_match(mk_rgb(20, 0, 0), 1'b0);        // equal distance, distinct colours
    push_load(300, mk_rgb(0, 200, 0));
    push_load(301, mk_rgb(0, 0, 200));
    push_load(302, mk_rgb(200, 0, 0));
    push_match(mk_rgb(0, 100, 0), 1'b1);       // tie with black at index 0
    push_match(mk_rgb(0, 150, 0), 1'b0);
    push_match(mk_rgb(0, 0, 150), 1'b1);
    push_match(mk_rgb(150, 0, 0), 1'b0);
    n_matches = 10;
    hold_at   = n_matches + 4;

    // Random palette, then a random mix of loads and matches
    for (k = 0; k < TABLE_ENTRIES; k++) push_load(k, pick_colour());
    for (k = 0; k < 140; k++) begin
      if ($urandom_range(0, 99) < 45) begin
        case ($urandom_range(0, 3))
          0: c = random_rgb();
          1: c = colour_pool[$urandom_range(0, POOL_SIZE - 1)];
          2: begin
            c = colour_pool[$urandom_range(0, POOL_SIZE - 1)];
            c = mk_rgb(nudge(c.r), nudge(c.g), nudge(c.b));
          end
          default: c = mk_rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                              $urandom_range(0, 1) * 255);
        endcase
        push_match(c, 1'($urandom_range(0, 1)));
      end else begin
        push_load($urandom_range(0, TABLE_ENTRIES - 1), pick_colour());
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid || expected_matches.size() != 0)
      @(posedge clk);
    repeat (TABLE_ENTRIES + 16) @(posedge clk);
    errors += expected_matches.size();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive_words
    word_t w;
    rgb_t  q;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      // Accepted word: update the palette copy or queue the expected match
      if (in_valid && !in_stall) begin
        q = mk_rgb(in_red, in_green, in_blue);
        if (in_cmd == CMD_LOAD) begin
          if (int'(in_entry_index) < TABLE_ENTRIES) palette_copy[in_entry_index] = q;
        end else begin
          expected_matches.push_back(nearest_entry(q, in_is_last));
        end
      end
      // Payload only moves when nothing is waiting to be taken
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() >= TAIL_WORDS && $urandom_range(0, 7) == 0) begin
          tx_gap   <= $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          in_cmd         <= w.cmd;
          in_entry_index <= w.entry_index;
          in_red         <= w.colour.r;
          in_green       <= w.colour.g;
          in_blue        <= w.colour.b;
          in_is_last     <= w.is_last;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- long output hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : check_results
    match_t got;
    match_t want;
    int     gap_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap    <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.idx      = out_best_index;
        got.colour   = mk_rgb(out_match_red, out_match_green, out_match_blue);
        got.distance = out_best_distance;
        got.last     = out_last_out;
        results_seen <= results_seen + 1;
        if (expected_matches.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result idx=%0d rgb=%h dist=%0d last=%b",
                     $realtime, got.idx, got.colour, got.distance, got.last);
        end else begin
          want = expected_matches.pop_front();
          if (got.idx !== want.idx || got.colour !== want.colour ||
              got.distance !== want.distance || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch exp idx=%0d rgb=%h dist=%0d last=%b,",
                        " got idx=%0d rgb=%h dist=%0d last=%b"},
                       $realtime, want.idx, want.colour, want.distance, want.last,
                       got.idx, got.colour, got.distance, got.last);
          end
        end
      end
      // Random stall bursts, none in the tail of the run
      gap_next = rx_gap;
      if (gap_next != 0)
        gap_next--;
      else if (pending_words.size() >= TAIL_WORDS && $urandom_range(0, 7) == 0)
        gap_next = $urandom_range(1, 15);
      rx_gap    <= gap_next;
      out_stall <= (gap_next != 0) || (hold_left != 0);
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
